>>> hw/rtl/qph_pkg.sv
// Shared types and constants for the quadratic-probe hash table.
// Used by every module under hw/rtl; depends on nothing.
`default_nettype none

package qph_pkg;

    // Default table size
    localparam int TABLE_SLOTS_DEF = 2048;

    // Fixed field widths
    localparam int CMD_W      = 2;
    localparam int KEY_W      = 31;
    localparam int SLOT_IN_W  = 12;
    localparam int SLOT_OUT_W = 11;
    localparam int ENTRY_W    = 32;
    localparam int PROD_W     = 2 * KEY_W;

    // Entry encodings
    localparam logic [ENTRY_W-1:0] ENTRY_EMPTY  = 32'h0000_0000;
    localparam logic [ENTRY_W-1:0] MARK_DELETED = 32'h8000_0000;

    // Commands
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_DELETE = 2'd2
    } cmd_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL_Q,
        ST_MUL_QN,
        ST_MOD,
        ST_ADDR,
        ST_CHECK,
        ST_STEP,
        ST_DELETE,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/qph_arith.sv
// Shared arithmetic unit: one registered 31x31 multiplier and one
// add-then-reduce-mod-slots stage. Depends on qph_pkg.
`default_nettype none

module qph_arith #(
    parameter int TABLE_SLOTS = qph_pkg::TABLE_SLOTS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             mul_en,
    input  wire logic [qph_pkg::KEY_W-1:0]        mul_a,
    input  wire logic [qph_pkg::KEY_W-1:0]        mul_b,
    output logic      [qph_pkg::PROD_W-1:0]       prod,
    input  wire logic [$clog2(TABLE_SLOTS):0]     add_a,
    input  wire logic [$clog2(TABLE_SLOTS):0]     add_b,
    output logic      [$clog2(TABLE_SLOTS)-1:0]   add_mod
);

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam logic [IW+1:0] SLOTS_SUM = (IW + 2)'(TABLE_SLOTS);

    logic [qph_pkg::PROD_W-1:0] prod_reg;
    logic [IW+1:0]              sum;
    logic [IW+1:0]              diff;

    // Multiplier, registered
    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= qph_pkg::PROD_W'(mul_a) * qph_pkg::PROD_W'(mul_b);
        end
    end

    assign prod = prod_reg;

    // Modular add; operands keep the sum below twice the slot count
    always_comb
    begin
        sum  = {1'b0, add_a} + {1'b0, add_b};
        diff = sum - SLOTS_SUM;
        if (sum >= SLOTS_SUM)
        begin
            add_mod = diff[IW-1:0];
        end
        else
        begin
            add_mod = sum[IW-1:0];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/qph_store.sv
// Slot store: one write port and one read port with registered read data.
// Depends on qph_pkg.
`default_nettype none

module qph_store #(
    parameter int TABLE_SLOTS = qph_pkg::TABLE_SLOTS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             wr_en,
    input  wire logic [$clog2(TABLE_SLOTS)-1:0]   wr_addr,
    input  wire logic [qph_pkg::ENTRY_W-1:0]      wr_data,
    input  wire logic                             rd_en,
    input  wire logic [$clog2(TABLE_SLOTS)-1:0]   rd_addr,
    output logic      [qph_pkg::ENTRY_W-1:0]      rd_data
);

    logic [qph_pkg::ENTRY_W-1:0] mem_array [TABLE_SLOTS];
    logic [qph_pkg::ENTRY_W-1:0] rd_data_reg;

    // Write and read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/quadratic_probe_hash_table.sv
// Insert/search step through MUL_Q, MUL_QN, MOD, ADDR and CHECK before the result loads in DONE;
// each further probe adds STEP, ADDR and CHECK (shared mod-add unit, one store read).
// Delete passes through DELETE to DONE; a zero key or unused command goes straight to DONE.
// Throughput: one item at a time; input is ready again once the result loads into the
// output register, and a held result delays it.
// Reset: a clearing pass writes every slot empty; no input is taken.
`default_nettype none

module quadratic_probe_hash_table #(
    parameter int TABLE_SLOTS = qph_pkg::TABLE_SLOTS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [qph_pkg::CMD_W-1:0]          cmd,
    input  wire logic [qph_pkg::KEY_W-1:0]          key,
    input  wire logic [qph_pkg::SLOT_IN_W-1:0]      slot,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic      [qph_pkg::SLOT_OUT_W-1:0]     slot_res,
    output logic                                    ok
);

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam int AW = IW + 1;
    localparam logic [qph_pkg::KEY_W-1:0] RECIP =
        qph_pkg::KEY_W'((64'd1 << qph_pkg::KEY_W) / TABLE_SLOTS);
    localparam logic [qph_pkg::KEY_W-1:0] SLOTS_MUL = qph_pkg::KEY_W'(TABLE_SLOTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SLOTS - 1);

    // Control registers
    qph_pkg::state_t state_reg, state_next;
    logic [IW-1:0]   clr_reg, clr_next;
    logic            out_valid_reg, out_valid_next;

    // Payload registers
    logic [qph_pkg::CMD_W-1:0]      cmd_reg, cmd_next;
    logic [qph_pkg::KEY_W-1:0]      key_reg, key_next;
    logic [qph_pkg::SLOT_IN_W-1:0]  slot_reg, slot_next;
    logic [IW-1:0]                  base_reg, base_next;
    logic [IW-1:0]                  sq_reg, sq_next;
    logic [IW-1:0]                  d_reg, d_next;
    logic [IW-1:0]                  step_reg, step_next;
    logic [IW-1:0]                  probe_reg, probe_next;
    logic                           res_ok_reg, res_ok_next;
    logic [IW-1:0]                  res_slot_reg, res_slot_next;
    logic                           out_ok_reg, out_ok_next;
    logic [qph_pkg::SLOT_OUT_W-1:0] out_slot_reg, out_slot_next;

    // Shared unit and store hookup
    logic                            mul_en;
    logic [qph_pkg::KEY_W-1:0]       mul_a, mul_b;
    logic [qph_pkg::PROD_W-1:0]      prod;
    logic [AW-1:0]                   add_a, add_b;
    logic [IW-1:0]                   add_mod;
    logic                            mem_wr_en, mem_rd_en;
    logic [IW-1:0]                   mem_wr_addr, mem_rd_addr;
    logic [qph_pkg::ENTRY_W-1:0]     mem_wr_data, mem_rd_data;

    // Decode helpers
    logic                            in_xfer;
    logic                            out_free;
    logic                            is_insert;
    logic                            entry_empty, entry_free, entry_match;
    logic                            probe_done, last_probe;
    logic                            del_in_range;
    logic [qph_pkg::KEY_W-1:0]       rem_raw;
    logic [IW+qph_pkg::SLOT_IN_W-1:0]  slot_wide;
    logic [IW+qph_pkg::SLOT_OUT_W-1:0] res_wide;

    qph_arith #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_arith (
        .clk     (clk),
        .mul_en  (mul_en),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .prod    (prod),
        .add_a   (add_a),
        .add_b   (add_b),
        .add_mod (add_mod)
    );

    qph_store #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Handshake and entry decode
    assign in_ready  = (state_reg == qph_pkg::ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign ok        = out_ok_reg;
    assign slot_res  = out_slot_reg;

    assign is_insert    = (cmd_reg == qph_pkg::CMD_INSERT);
    assign entry_empty  = (mem_rd_data == qph_pkg::ENTRY_EMPTY);
    assign entry_free   = entry_empty || mem_rd_data[qph_pkg::ENTRY_W-1];
    assign entry_match  = (mem_rd_data == {1'b0, key_reg});
    assign probe_done   = is_insert ? entry_free : (entry_match || entry_empty);
    assign last_probe   = (step_reg == LAST_IDX);
    assign del_in_range = (32'(slot_reg) < 32'(TABLE_SLOTS));
    assign rem_raw      = key_reg - prod[qph_pkg::KEY_W-1:0];
    assign slot_wide    = {{IW{1'b0}}, slot_reg};
    assign res_wide     = {{qph_pkg::SLOT_OUT_W{1'b0}}, res_slot_reg};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            qph_pkg::ST_CLEAR:
            begin
                if (clr_reg == LAST_IDX)
                begin
                    state_next = qph_pkg::ST_IDLE;
                end
            end
            qph_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    unique case (cmd) inside
                        qph_pkg::CMD_INSERT, qph_pkg::CMD_SEARCH:
                        begin
                            if (key == '0)
                            begin
                                state_next = qph_pkg::ST_DONE;
                            end
                            else
                            begin
                                state_next = qph_pkg::ST_MUL_Q;
                            end
                        end
                        qph_pkg::CMD_DELETE: state_next = qph_pkg::ST_DELETE;
                        default:             state_next = qph_pkg::ST_DONE;
                    endcase
                end
            end
            qph_pkg::ST_MUL_Q:  state_next = qph_pkg::ST_MUL_QN;
            qph_pkg::ST_MUL_QN: state_next = qph_pkg::ST_MOD;
            qph_pkg::ST_MOD:    state_next = qph_pkg::ST_ADDR;
            qph_pkg::ST_ADDR:   state_next = qph_pkg::ST_CHECK;
            qph_pkg::ST_CHECK:
            begin
                if (probe_done || last_probe)
                begin
                    state_next = qph_pkg::ST_DONE;
                end
                else
                begin
                    state_next = qph_pkg::ST_STEP;
                end
            end
            qph_pkg::ST_STEP:   state_next = qph_pkg::ST_ADDR;
            qph_pkg::ST_DELETE: state_next = qph_pkg::ST_DONE;
            qph_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = qph_pkg::ST_IDLE;
                end
            end
            default: state_next = qph_pkg::ST_IDLE;
        endcase
    end

    // Datapath controls and next values
    always_comb
    begin
        clr_next      = clr_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        slot_next     = slot_reg;
        base_next     = base_reg;
        sq_next       = sq_reg;
        d_next        = d_reg;
        step_next     = step_reg;
        probe_next    = probe_reg;
        res_ok_next   = res_ok_reg;
        res_slot_next = res_slot_reg;
        out_ok_next   = out_ok_reg;
        out_slot_next = out_slot_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mul_en        = 1'b0;
        mul_a         = key_reg;
        mul_b         = RECIP;
        add_a         = '0;
        add_b         = '0;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = probe_reg;
        mem_wr_data   = {1'b0, key_reg};
        mem_rd_en     = 1'b0;
        mem_rd_addr   = add_mod;

        unique case (state_reg)
            qph_pkg::ST_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_reg;
                mem_wr_data = qph_pkg::ENTRY_EMPTY;
                clr_next    = clr_reg + 1'b1;
            end
            qph_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd_next      = cmd;
                    key_next      = key;
                    slot_next     = slot;
                    res_ok_next   = 1'b0;
                    res_slot_next = '0;
                end
            end
            // quotient estimate = key * floor(2^31 / slots) >> 31
            qph_pkg::ST_MUL_Q:
            begin
                mul_en = 1'b1;
            end
            qph_pkg::ST_MUL_QN:
            begin
                mul_en = 1'b1;
                mul_a  = prod[qph_pkg::PROD_W-1:qph_pkg::KEY_W];
                mul_b  = SLOTS_MUL;
            end
            // remainder is below twice the slot count; one reduce fixes it
            qph_pkg::ST_MOD:
            begin
                add_a     = rem_raw[AW-1:0];
                base_next = add_mod;
                sq_next   = '0;
                d_next    = IW'(1);
                step_next = '0;
            end
            qph_pkg::ST_ADDR:
            begin
                add_a      = {1'b0, base_reg};
                add_b      = {1'b0, sq_reg};
                probe_next = add_mod;
                mem_rd_en  = 1'b1;
            end
            qph_pkg::ST_CHECK:
            begin
                if (is_insert && entry_free)
                begin
                    mem_wr_en     = 1'b1;
                    res_ok_next   = 1'b1;
                    res_slot_next = probe_reg;
                end
                else if (!is_insert && entry_match)
                begin
                    res_ok_next   = 1'b1;
                    res_slot_next = probe_reg;
                end
                // (i+1)^2 = i^2 + (2i+1)
                if (!(probe_done || last_probe))
                begin
                    add_a     = {1'b0, sq_reg};
                    add_b     = {1'b0, d_reg};
                    sq_next   = add_mod;
                    step_next = step_reg + 1'b1;
                end
            end
            qph_pkg::ST_STEP:
            begin
                add_a  = {1'b0, d_reg};
                add_b  = AW'(2);
                d_next = add_mod;
            end
            qph_pkg::ST_DELETE:
            begin
                if (del_in_range)
                begin
                    mem_wr_en     = 1'b1;
                    mem_wr_addr   = slot_wide[IW-1:0];
                    mem_wr_data   = qph_pkg::MARK_DELETED;
                    res_ok_next   = 1'b1;
                    res_slot_next = slot_wide[IW-1:0];
                end
            end
            qph_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = res_ok_reg;
                    out_slot_next  = res_wide[qph_pkg::SLOT_OUT_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qph_pkg::ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        slot_reg     <= slot_next;
        base_reg     <= base_next;
        sq_reg       <= sq_next;
        d_reg        <= d_next;
        step_reg     <= step_next;
        probe_reg    <= probe_next;
        res_ok_reg   <= res_ok_next;
        res_slot_reg <= res_slot_next;
        out_ok_reg   <= out_ok_next;
        out_slot_reg <= out_slot_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/qph_checker.sv
// Port-level checks for the quadratic-probe hash table, bound to the top level.
// Depends on qph_pkg and quadratic_probe_hash_table.
`default_nettype none

module qph_checker #(
    parameter int TABLE_SLOTS = qph_pkg::TABLE_SLOTS_DEF
) (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_ready,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire logic [qph_pkg::SLOT_OUT_W-1:0] slot_res,
    input wire logic                           ok
);

    // A waiting result holds until its transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(slot_res) && $stable(ok))
    else $error("result changed or dropped while stalled");

    // Failed results carry slot zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> slot_res == '0)
    else $error("failed result with nonzero slot");

    // Successful results name a slot inside the table
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ok |-> 32'(slot_res) < 32'(TABLE_SLOTS))
    else $error("slot out of table range");

    // One item in flight: busy after an input transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

endmodule

bind quadratic_probe_hash_table qph_checker #(
    .TABLE_SLOTS (TABLE_SLOTS)
) u_qph_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .slot_res  (slot_res),
    .ok        (ok)
);

`default_nettype wire
